### rtl/hlis_pkg.sv
// hlis_pkg: shared types and constants of the horizontal linear image scaler
// payload structs, sequencer states, register indexes, size limits and divider request/response
// no dependencies
package hlis_pkg;

  // largest source and destination sizes; register and divider widths are sized for these
  localparam int MAX_SRC_SIZE = 256;
  localparam int MAX_DST_SIZE = 1024;

  localparam int POS_W      = 10;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int CH_IDX_W   = $clog2(NUM_CH);
  localparam int SRC_REG_W  = 9;
  localparam int DST_REG_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // divider sizing: numerator below divisor * 2**QUO_W in every use
  localparam int NUM_W = 19;
  localparam int DEN_W = DST_REG_W;
  localparam int QUO_W = 9;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X_START,
    ST_DIV_X,
    ST_DIV_Y_START,
    ST_DIV_Y,
    ST_RD_P,
    ST_RD_Q,
    ST_LAT_Q,
    ST_BLEND_START,
    ST_BLEND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [CH_W-1:0]  in_red;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            range_error;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/hlis_chan_if.sv
// hlis_chan_if: valid/ready channel carrying one payload struct per transfer
// payload type is a parameter, normally a struct from hlis_pkg
interface hlis_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/horizontal_linear_image_scaler.sv
// horizontal_linear_image_scaler: frame store plus sequencer around one shared divider
// depends on hlis_pkg, hlis_chan_if, hlis_ram, hlis_div
//
//   channel  dir  payload                                   transfer when
//   in_i     in   operation, pos_x, pos_y, in_red/green/blue  valid && ready
//   out_o    out  out_red/green/blue, range_error            valid && ready
//   cfg      in   cfg_idx_i, cfg_data_i                      cfg_we_i
//
// a load is written to the frame store at the transfer
// an in-range query makes five passes through the 9-step divider (column, row, then one
// per colour) plus frame store reads in ST_RD_P, ST_RD_Q and ST_LAT_Q
// an out-of-range query goes straight to the output state; in_i.ready is high only while idle
// a finished result sits in the output register, so the next item is taken while it waits
// reset clears the sequencer and output valid and sets the size registers to 256; the
// frame store is not cleared and must be loaded before it is queried
module horizontal_linear_image_scaler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hlis_chan_if.sink                        in_i,
  hlis_chan_if.source                      out_o,
  input  logic                             cfg_we_i,
  input  logic [hlis_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hlis_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int MAX_SRC_SIZE = hlis_pkg::MAX_SRC_SIZE;
  localparam int MAX_DST_SIZE = hlis_pkg::MAX_DST_SIZE;
  localparam int DEPTH     = MAX_SRC_SIZE * MAX_SRC_SIZE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SRC_W     = hlis_pkg::SRC_REG_W;
  localparam int DST_W     = hlis_pkg::DST_REG_W;
  localparam int POS_W     = hlis_pkg::POS_W;
  localparam int CH_W      = hlis_pkg::CH_W;
  localparam int NUM_CH    = hlis_pkg::NUM_CH;
  localparam int PIX_W     = hlis_pkg::PIX_W;
  localparam int CH_IDX_W  = hlis_pkg::CH_IDX_W;
  localparam int NUM_W     = hlis_pkg::NUM_W;

  // size registers, raw as written
  logic [SRC_W-1:0] src_w_q, src_w_d;
  logic [SRC_W-1:0] src_h_q, src_h_d;
  logic [DST_W-1:0] dst_w_q, dst_w_d;
  logic [DST_W-1:0] dst_h_q, dst_h_d;

  // effective sizes after clamping
  logic [SRC_W-1:0] eff_sw, eff_sh;
  logic [DST_W-1:0] eff_dw, eff_dh;

  hlis_pkg::state_e state_q, state_d;

  // query context
  logic [POS_W-1:0]    x_q, x_d;
  logic [POS_W-1:0]    y_q, y_d;
  logic                err_q, err_d;
  logic [SRC_W-1:0]    sx_q, sx_d;
  logic [DST_W-1:0]    r_q, r_d;
  logic [SRC_W-1:0]    sy_q, sy_d;
  logic [PIX_W-1:0]    p_q, p_d;
  logic [PIX_W-1:0]    q_q, q_d;
  logic [CH_IDX_W-1:0] ch_q, ch_d;
  logic [CH_W-1:0]     res_q [NUM_CH];
  logic [CH_W-1:0]     res_d [NUM_CH];

  // output register
  logic                 out_valid_q, out_valid_d;
  hlis_pkg::out_item_t  out_data_q, out_data_d;

  hlis_pkg::in_item_t   in_item;
  logic                 in_xfer;
  logic                 load_ok;
  logic                 query_oob;
  logic                 out_free;
  logic                 out_load;
  logic                 in_ready;

  // frame store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PIX_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;
  logic [SRC_W:0]    sx_inc;
  logic [SRC_W-1:0]  nx;
  logic [SRC_W-1:0]  rd_col;

  // shared divider and its operand selection
  hlis_pkg::div_req_t div_req;
  hlis_pkg::div_rsp_t div_rsp;
  logic [NUM_W-1:0]   mul_a, mul_b;
  logic [NUM_W-1:0]   pos_prod;
  logic [CH_W-1:0]    ch_p, ch_q_val;
  logic [DST_W-1:0]   wt_left;
  logic [NUM_W-1:0]   blend_num;

  // ---------------------------------------------------------------- config

  always_comb begin
    src_w_d = src_w_q;
    src_h_d = src_h_q;
    dst_w_d = dst_w_q;
    dst_h_d = dst_h_q;
    if (cfg_we_i) begin
      unique case (hlis_pkg::cfg_reg_e'(cfg_idx_i))
        hlis_pkg::REG_SRC_WIDTH:  src_w_d = cfg_data_i[SRC_W-1:0];
        hlis_pkg::REG_SRC_HEIGHT: src_h_d = cfg_data_i[SRC_W-1:0];
        hlis_pkg::REG_DST_WIDTH:  dst_w_d = cfg_data_i[DST_W-1:0];
        hlis_pkg::REG_DST_HEIGHT: dst_h_d = cfg_data_i[DST_W-1:0];
        default: ;
      endcase
    end
  end

  // zero source size counts as one, oversize saturates
  assign eff_sw = (src_w_q == '0) ? SRC_W'(1) :
                  (int'(src_w_q) > MAX_SRC_SIZE) ? SRC_W'(MAX_SRC_SIZE) : src_w_q;
  assign eff_sh = (src_h_q == '0) ? SRC_W'(1) :
                  (int'(src_h_q) > MAX_SRC_SIZE) ? SRC_W'(MAX_SRC_SIZE) : src_h_q;
  // a zero destination size is kept: every query in that direction is out of range
  assign eff_dw = (int'(dst_w_q) > MAX_DST_SIZE) ? DST_W'(MAX_DST_SIZE) : dst_w_q;
  assign eff_dh = (int'(dst_h_q) > MAX_DST_SIZE) ? DST_W'(MAX_DST_SIZE) : dst_h_q;

  // ---------------------------------------------------------------- input side

  assign in_item   = in_i.payload;
  assign in_i.ready = in_ready;
  assign in_xfer   = in_i.valid && in_ready;

  assign load_ok   = (DST_W'(in_item.pos_x) < DST_W'(eff_sw)) &&
                     (DST_W'(in_item.pos_y) < DST_W'(eff_sh));
  assign query_oob = (DST_W'(in_item.pos_x) >= eff_dw) ||
                     (DST_W'(in_item.pos_y) >= eff_dh);

  // loads go straight into the store at the transfer, out-of-range loads dropped
  assign ram_we    = in_xfer && (in_item.operation == hlis_pkg::OP_LOAD) && load_ok;
  assign ram_waddr = ADDR_W'(int'(in_item.pos_y) * MAX_SRC_SIZE + int'(in_item.pos_x));
  assign ram_wdata = {in_item.in_red, in_item.in_green, in_item.in_blue};

  // right-hand neighbour, clamped at the last column
  assign sx_inc    = {1'b0, sx_q} + (SRC_W + 1)'(1);
  assign nx        = (sx_inc < {1'b0, eff_sw}) ? sx_inc[SRC_W-1:0] : eff_sw - SRC_W'(1);
  assign rd_col    = (state_q == hlis_pkg::ST_RD_Q) ? nx : sx_q;
  assign ram_raddr = ADDR_W'(int'(sy_q) * MAX_SRC_SIZE + int'(rd_col));

  hlis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- divider operands

  // position scaling: x*src_w or y*src_h, one multiplier shared by both
  assign mul_a    = (state_q == hlis_pkg::ST_DIV_Y_START) ? NUM_W'(y_q) : NUM_W'(x_q);
  assign mul_b    = (state_q == hlis_pkg::ST_DIV_Y_START) ? NUM_W'(eff_sh) : NUM_W'(eff_sw);
  assign pos_prod = mul_a * mul_b;

  // blend numerator p*(D-r) + q*r for the current colour, red first
  assign ch_p      = p_q[CH_W * (NUM_CH - 1 - int'(ch_q)) +: CH_W];
  assign ch_q_val  = q_q[CH_W * (NUM_CH - 1 - int'(ch_q)) +: CH_W];
  assign wt_left   = eff_dw - r_q;
  assign blend_num = (NUM_W'(ch_p) * NUM_W'(wt_left)) + (NUM_W'(ch_q_val) * NUM_W'(r_q));

  hlis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- sequencer

  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hlis_pkg::ST_IDLE: begin
        if (in_xfer && (in_item.operation == hlis_pkg::OP_QUERY)) begin
          state_d = query_oob ? hlis_pkg::ST_OUT : hlis_pkg::ST_DIV_X_START;
        end
      end
      hlis_pkg::ST_DIV_X_START: state_d = hlis_pkg::ST_DIV_X;
      hlis_pkg::ST_DIV_X: begin
        if (div_rsp.done) state_d = hlis_pkg::ST_DIV_Y_START;
      end
      hlis_pkg::ST_DIV_Y_START: state_d = hlis_pkg::ST_DIV_Y;
      hlis_pkg::ST_DIV_Y: begin
        if (div_rsp.done) state_d = hlis_pkg::ST_RD_P;
      end
      hlis_pkg::ST_RD_P:        state_d = hlis_pkg::ST_RD_Q;
      hlis_pkg::ST_RD_Q:        state_d = hlis_pkg::ST_LAT_Q;
      hlis_pkg::ST_LAT_Q:       state_d = hlis_pkg::ST_BLEND_START;
      hlis_pkg::ST_BLEND_START: state_d = hlis_pkg::ST_BLEND;
      hlis_pkg::ST_BLEND: begin
        if (div_rsp.done) begin
          state_d = (ch_q == CH_IDX_W'(NUM_CH - 1)) ? hlis_pkg::ST_OUT
                                                    : hlis_pkg::ST_BLEND_START;
        end
      end
      hlis_pkg::ST_OUT: begin
        if (out_free) state_d = hlis_pkg::ST_IDLE;
      end
      default: state_d = hlis_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = pos_prod;
    div_req.den   = eff_dw;
    unique case (state_q)
      hlis_pkg::ST_IDLE:        in_ready = 1'b1;
      hlis_pkg::ST_DIV_X_START: div_req.start = 1'b1;
      hlis_pkg::ST_DIV_Y_START: begin
        div_req.start = 1'b1;
        div_req.den   = eff_dh;
      end
      hlis_pkg::ST_BLEND_START: begin
        div_req.start = 1'b1;
        div_req.num   = blend_num;
      end
      hlis_pkg::ST_OUT:         out_load = out_free;
      default: ;
    endcase
  end

  // datapath captures along the sequence
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    err_d = err_q;
    sx_d  = sx_q;
    r_d   = r_q;
    sy_d  = sy_q;
    p_d   = p_q;
    q_d   = q_q;
    ch_d  = ch_q;
    res_d = res_q;
    if (in_xfer) begin
      x_d   = in_item.pos_x;
      y_d   = in_item.pos_y;
      err_d = query_oob;
    end
    if ((state_q == hlis_pkg::ST_DIV_X) && div_rsp.done) begin
      sx_d = div_rsp.quo[SRC_W-1:0];
      r_d  = div_rsp.rem;
    end
    if ((state_q == hlis_pkg::ST_DIV_Y) && div_rsp.done) begin
      sy_d = div_rsp.quo[SRC_W-1:0];
    end
    // registered read: the data arrives in the cycle after its address
    if (state_q == hlis_pkg::ST_RD_Q) begin
      p_d = ram_rdata;
    end
    if (state_q == hlis_pkg::ST_LAT_Q) begin
      q_d  = ram_rdata;
      ch_d = '0;
    end
    if ((state_q == hlis_pkg::ST_BLEND) && div_rsp.done) begin
      res_d[ch_q] = div_rsp.quo[CH_W-1:0];
      ch_d        = ch_q + CH_IDX_W'(1);
    end
  end

  // output register, taken over when empty or being drained
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d            = 1'b1;
      out_data_d.out_red     = err_q ? '0 : res_q[0];
      out_data_d.out_green   = err_q ? '0 : res_q[1];
      out_data_d.out_blue    = err_q ? '0 : res_q[2];
      out_data_d.range_error = err_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  // ---------------------------------------------------------------- registers

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hlis_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      src_w_q     <= SRC_W'(256);
      src_h_q     <= SRC_W'(256);
      dst_w_q     <= DST_W'(256);
      dst_h_q     <= DST_W'(256);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ch_q        <= ch_d;
      src_w_q     <= src_w_d;
      src_h_q     <= src_h_d;
      dst_w_q     <= dst_w_d;
      dst_h_q     <= dst_h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_d_reg: begin
      x_q        <= x_d;
      y_q        <= y_d;
      err_q      <= err_d;
      sx_q       <= sx_d;
      r_q        <= r_d;
      sy_q       <= sy_d;
      p_q        <= p_d;
      q_q        <= q_d;
      res_q      <= res_d;
      out_data_q <= out_data_d;
    end
  end

  // ---------------------------------------------------------------- assertions

  // the divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == hlis_pkg::ST_DIV_X || state_q == hlis_pkg::ST_DIV_Y ||
                      state_q == hlis_pkg::ST_BLEND))
    else $error("divider finished outside a wait state");

  // frame store writes happen only on a load transfer while idle
  a_store_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == hlis_pkg::ST_IDLE))
    else $error("frame store written while busy");

  // column remainder must stay below the destination width
  a_rem_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_rsp.done && state_q == hlis_pkg::ST_DIV_X) |-> (div_rsp.rem < eff_dw))
    else $error("column remainder not below destination width");

  // an out-of-range result carries no colour
  a_error_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.range_error) |->
      (out_o.payload.out_red == '0 && out_o.payload.out_green == '0 &&
       out_o.payload.out_blue == '0))
    else $error("range error with non-zero colour");

  // a new result is only loaded while the sequencer sits in its output state
  a_out_load_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q) && $past(rst_ni)) |->
      ($past(state_q) == hlis_pkg::ST_OUT))
    else $error("result loaded outside the output state");

endmodule

### rtl/hlis_ram.sv
// hlis_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
module hlis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hlis_div.sv
// hlis_div: shared restoring divider, one quotient bit per cycle
// depends on hlis_pkg (div_req_t, div_rsp_t and widths)
module hlis_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hlis_pkg::div_req_t  req_i,
  output hlis_pkg::div_rsp_t  rsp_o
);

  localparam int NUM_W = hlis_pkg::NUM_W;
  localparam int DEN_W = hlis_pkg::DEN_W;
  localparam int QUO_W = hlis_pkg::QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // partial remainder shifted left with the next numerator bit
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      rem_d  = DEN_W'(req_i.num[NUM_W-1:QUO_W]);
      quo_d  = req_i.num[QUO_W-1:0];
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
